>>> rtl/core/aff2d_pkg.sv
// Shared types, constants and helpers of the 2D affine transform engine.
// Depends on nothing; every other file of the block refers to it by scope.
`default_nettype none

package aff2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int NUM_ELEM  = 9;

    localparam logic [1:0] CMD_IDENTITY  = 2'd0;
    localparam logic [1:0] CMD_COMPOSE   = 2'd1;
    localparam logic [1:0] CMD_TRANSFORM = 2'd2;

    localparam logic signed [DATA_W-1:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic       last_sum;
    } tag_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        tag_t tag;
    } mac_ctl_t;

    typedef struct packed {
        logic                     valid;
        tag_t                     tag;
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } mac_res_t;

    // Flat index of a row-major 3x3 element.
    function automatic logic [3:0] elem_idx(input logic [1:0] row, input logic [1:0] col);
        return (4'(row) << 1) + 4'(row) + 4'(col);
    endfunction

    // Identity matrix element at a flat index.
    function automatic logic signed [DATA_W-1:0] id_elem(input logic [3:0] idx);
        return (idx == 4'd0 || idx == 4'd4 || idx == 4'd8) ? FIX_ONE : '0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/aff2d_if.sv
// Request and response channel interfaces of the affine transform engine.
// Depends on aff2d_pkg for the payload widths.
`default_nettype none

interface aff2d_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             command;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_00;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_01;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_02;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_10;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_11;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_12;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_20;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_21;
    logic signed [aff2d_pkg::DATA_W-1:0]    elem_22;

    modport source (
        output valid, command, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
               elem_20, elem_21, elem_22,
        input  ready
    );
    modport sink (
        input  valid, command, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
               elem_20, elem_21, elem_22,
        output ready
    );
endinterface

interface aff2d_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aff2d_pkg::DATA_W-1:0]    out_x;
    logic signed [aff2d_pkg::DATA_W-1:0]    out_y;
    logic                                   saturated;

    modport source (
        output valid, out_x, out_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, saturated,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/aff2d_mac.sv
// Shared multiply-accumulate unit: operand register, 32x32 multiplier, 66-bit
// accumulator, then floor shift and 32-bit saturation. Depends on aff2d_pkg.
`default_nettype none

module aff2d_mac (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire aff2d_pkg::mac_ctl_t                 ctl,
    input  wire logic signed [aff2d_pkg::DATA_W-1:0] op_a,
    input  wire logic signed [aff2d_pkg::DATA_W-1:0] op_b,
    output aff2d_pkg::mac_res_t                      res
);

    aff2d_pkg::mac_ctl_t                    s1_ctl_reg;
    aff2d_pkg::mac_ctl_t                    s2_ctl_reg;
    aff2d_pkg::mac_ctl_t                    s3_ctl_reg;
    logic signed [aff2d_pkg::DATA_W-1:0]    a_reg;
    logic signed [aff2d_pkg::DATA_W-1:0]    b_reg;
    logic signed [aff2d_pkg::PROD_W-1:0]    prod_reg;
    logic signed [aff2d_pkg::ACC_W-1:0]     acc_reg;
    logic signed [aff2d_pkg::ACC_W-1:0]     acc_base;
    logic signed [aff2d_pkg::ACC_W-1:0]     shifted;
    logic [aff2d_pkg::ACC_W-aff2d_pkg::DATA_W:0] high_bits;
    logic                                   out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= op_a;
        b_reg    <= op_b;
        prod_reg <= a_reg * b_reg;
        if (s2_ctl_reg.valid)
        begin
            acc_reg <= acc_base + aff2d_pkg::ACC_W'(prod_reg);
        end
    end

    // Restart the sum on the first term of each dot product.
    assign acc_base = s2_ctl_reg.first ? '0 : acc_reg;

    assign shifted      = acc_reg >>> aff2d_pkg::FRAC_BITS;
    assign high_bits    = shifted[aff2d_pkg::ACC_W-1:aff2d_pkg::DATA_W-1];
    assign out_of_range = !((&high_bits) || (~|high_bits));

    always_comb
    begin
        res.valid = s3_ctl_reg.valid && s3_ctl_reg.last;
        res.tag   = s3_ctl_reg.tag;
        res.sat   = out_of_range;
        if (out_of_range)
        begin
            res.value = shifted[aff2d_pkg::ACC_W-1] ? aff2d_pkg::SAT_MIN : aff2d_pkg::SAT_MAX;
        end
        else
        begin
            res.value = shifted[aff2d_pkg::DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/affine_2d_transform_engine.sv
// Top level of the 2D affine transform engine: matrix store, sequencer and
// output register around the shared MAC. Depends on aff2d_pkg, aff2d_if, aff2d_mac.
//
// Usage:
//   req  - valid/ready request channel: a command and a 3x3 Q16.16 matrix.
//          Load identity (0) resets the current matrix and the overflow flag.
//          Compose (1) replaces the current matrix with current times request.
//          Transform (2) maps point (elem_00, elem_01) by the current matrix.
//          Code 3 is dropped without effect.
//   rsp  - valid/ready response channel; only a transform makes a response:
//          out_x, out_y and saturated (this point or the last compose clipped).
//   One request is in flight at a time; ready is high only while idle.
//   Every product goes through one 32x32 multiplier, one term per cycle,
//   followed by a three-stage operand/product/accumulate pipeline.
//   A transform issues 6 products, a compose 27.
//   A finished response waits in its output register; the next request is
//   accepted meanwhile, and a later transform holds its result until the
//   receiver takes the pending one.
//   Reset loads the identity matrix, clears the overflow flag and empties rsp.
`default_nettype none

module affine_2d_transform_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aff2d_req_if.sink  req,
    aff2d_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [aff2d_pkg::DATA_W-1:0] mat_reg [0:aff2d_pkg::NUM_ELEM-1];
    logic signed [aff2d_pkg::DATA_W-1:0] in_reg  [0:aff2d_pkg::NUM_ELEM-1];
    logic                                compose_reg;
    logic [1:0]                          row_reg;
    logic [1:0]                          col_reg;
    logic [1:0]                          term_reg;
    logic signed [aff2d_pkg::DATA_W-1:0] rowbuf0_reg;
    logic signed [aff2d_pkg::DATA_W-1:0] rowbuf1_reg;
    logic signed [aff2d_pkg::DATA_W-1:0] x_hold_reg;
    logic signed [aff2d_pkg::DATA_W-1:0] y_hold_reg;
    logic                                sat_acc_reg;
    logic                                overflow_reg;
    logic signed [aff2d_pkg::DATA_W-1:0] out_x_reg;
    logic signed [aff2d_pkg::DATA_W-1:0] out_y_reg;
    logic                                out_sat_reg;
    logic                                out_valid_reg;

    logic                                accept;
    logic                                start_job;
    logic                                load_identity;
    logic [1:0]                          last_row;
    logic [1:0]                          last_col;
    logic                                last_sum;
    logic                                issue_done;
    logic                                out_load;
    aff2d_pkg::mac_ctl_t                 mac_ctl;
    logic signed [aff2d_pkg::DATA_W-1:0] op_a;
    logic signed [aff2d_pkg::DATA_W-1:0] op_b;
    aff2d_pkg::mac_res_t                 mac_res;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign load_identity = accept && (req.command == aff2d_pkg::CMD_IDENTITY);
    assign start_job     = accept && (req.command == aff2d_pkg::CMD_COMPOSE ||
                                      req.command == aff2d_pkg::CMD_TRANSFORM);

    // A compose walks a 3x3 grid of sums, a transform two rows of column 0.
    assign last_row   = compose_reg ? 2'd2 : 2'd1;
    assign last_col   = compose_reg ? 2'd2 : 2'd0;
    assign last_sum   = (row_reg == last_row) && (col_reg == last_col);
    assign issue_done = (state_reg == S_ISSUE) && (term_reg == 2'd2) && last_sum;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    //------------------------------------------------------------------
    // Operand selection: one term per cycle into the shared MAC
    //------------------------------------------------------------------
    always_comb
    begin
        mac_ctl.valid        = (state_reg == S_ISSUE);
        mac_ctl.first        = (term_reg == 2'd0);
        mac_ctl.last         = (term_reg == 2'd2);
        mac_ctl.tag.row      = row_reg;
        mac_ctl.tag.col      = col_reg;
        mac_ctl.tag.last_sum = last_sum;
        op_a = mat_reg[aff2d_pkg::elem_idx(row_reg, term_reg)];
        if (compose_reg)
        begin
            op_b = in_reg[aff2d_pkg::elem_idx(term_reg, col_reg)];
        end
        else
        begin
            // Point terms: x, y, then the implicit homogeneous one.
            case (term_reg)
                2'd0:    op_b = in_reg[0];
                2'd1:    op_b = in_reg[1];
                default: op_b = aff2d_pkg::FIX_ONE;
            endcase
        end
    end

    aff2d_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .res   (mac_res)
    );

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_job)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (issue_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (mac_res.valid && mac_res.tag.last_sum)
                begin
                    state_next = compose_reg ? S_IDLE : S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_job)
            begin
                row_reg  <= '0;
                col_reg  <= '0;
                term_reg <= '0;
            end
            else if (state_reg == S_ISSUE)
            begin
                // Advance term, then column, then row.
                if (term_reg == 2'd2)
                begin
                    term_reg <= '0;
                    if (col_reg == last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 2'd1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 2'd1;
                    end
                end
                else
                begin
                    term_reg <= term_reg + 2'd1;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Request capture
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start_job)
        begin
            compose_reg <= (req.command == aff2d_pkg::CMD_COMPOSE);
            in_reg[0]   <= req.elem_00;
            in_reg[1]   <= req.elem_01;
            in_reg[2]   <= req.elem_02;
            in_reg[3]   <= req.elem_10;
            in_reg[4]   <= req.elem_11;
            in_reg[5]   <= req.elem_12;
            in_reg[6]   <= req.elem_20;
            in_reg[7]   <= req.elem_21;
            in_reg[8]   <= req.elem_22;
        end
    end

    //------------------------------------------------------------------
    // Current matrix and overflow flag. A compose row is written back
    // only once its third sum is done; by then the issue side reads the
    // next row only.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++)
            begin
                mat_reg[i] <= aff2d_pkg::id_elem(4'(i));
            end
            overflow_reg <= 1'b0;
        end
        else if (load_identity)
        begin
            for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++)
            begin
                mat_reg[i] <= aff2d_pkg::id_elem(4'(i));
            end
            overflow_reg <= 1'b0;
        end
        else if (mac_res.valid && compose_reg)
        begin
            if (mac_res.tag.col == 2'd2)
            begin
                mat_reg[aff2d_pkg::elem_idx(mac_res.tag.row, 2'd0)] <= rowbuf0_reg;
                mat_reg[aff2d_pkg::elem_idx(mac_res.tag.row, 2'd1)] <= rowbuf1_reg;
                mat_reg[aff2d_pkg::elem_idx(mac_res.tag.row, 2'd2)] <= mac_res.value;
            end
            if (mac_res.tag.last_sum)
            begin
                overflow_reg <= sat_acc_reg || mac_res.sat;
            end
        end
    end

    // Hold finished sums until their row or point is complete.
    always_ff @(posedge clk)
    begin
        if (mac_res.valid)
        begin
            if (compose_reg)
            begin
                if (mac_res.tag.col == 2'd0)
                begin
                    rowbuf0_reg <= mac_res.value;
                end
                if (mac_res.tag.col == 2'd1)
                begin
                    rowbuf1_reg <= mac_res.value;
                end
            end
            else if (mac_res.tag.row == 2'd0)
            begin
                x_hold_reg <= mac_res.value;
            end
            else
            begin
                y_hold_reg <= mac_res.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_acc_reg <= 1'b0;
        end
        else if (start_job)
        begin
            sat_acc_reg <= 1'b0;
        end
        else if (mac_res.valid && mac_res.sat)
        begin
            sat_acc_reg <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Response register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg   <= x_hold_reg;
            out_y_reg   <= y_hold_reg;
            out_sat_reg <= sat_acc_reg || overflow_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_x     = out_x_reg;
    assign rsp.out_y     = out_y_reg;
    assign rsp.saturated = out_sat_reg;

endmodule

`default_nettype wire

>>> dv/tb_affine_2d_transform_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench of affine_2d_transform_engine: random and directed commands
// through the request channel, transformed points checked against a local predictor.
// Depends on aff2d_pkg, aff2d_if and the engine itself.

module tb_affine_2d_transform_engine;

    import aff2d_pkg::*;

    // Code 3 has no name in the package; the engine must drop it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_PCT     = 12;
    // Window with no idling on either side.
    localparam int QUIET_FROM   = 3000;
    localparam int QUIET_TO     = 4200;
    // One long receiver hold-off while the sender keeps offering requests.
    localparam int HOLD_AT      = 1500;
    localparam int HOLD_LEN     = 400;
    // Longest stretch without any handshake before the run is declared hung:
    // covers the long hold-off plus a compose, several times over.
    localparam int STALL_LIMIT  = 3000;
    // Cycles to let pass after the last response.
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;

    typedef logic [NUM_ELEM-1:0][DATA_W-1:0] mat_t;

    typedef struct packed {
        logic [1:0] command;
        mat_t       elem;       // elem[r*3+c] is row r, column c
        logic       wait_drain; // hold this request until every point has returned
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     sat;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;

    aff2d_req_if req ();
    aff2d_rsp_if rsp ();

    affine_2d_transform_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Requests waiting to be driven, and points the engine still owes us.
    request_t pending_requests [$];
    point_t   expected_points [$];

    // Predictor state: current matrix and the sticky overflow of the last compose.
    logic signed [DATA_W-1:0] cur_mat [NUM_ELEM];
    logic                     compose_clip;

    int  cyc = 0;
    int  n_total = 0;
    int  n_accepted = 0;
    int  n_issued = 0;
    int  n_returned = 0;
    int  n_fail = 0;
    int  stall_cycles = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;
    wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Three-term Q16.16 dot product: exact sum of full-width products, floor shift
    // by FRAC_BITS, then clamp to 32 bits. Any clamp sets clip.
    function automatic logic signed [DATA_W-1:0] q16_dot3(
        input logic signed [DATA_W-1:0] a0, b0, a1, b1, a2, b2,
        inout logic clip
    );
        logic signed [ACC_W-1:0] acc;
        acc = ACC_W'(a0) * ACC_W'(b0) + ACC_W'(a1) * ACC_W'(b1)
            + ACC_W'(a2) * ACC_W'(b2);
        acc = acc >>> FRAC_BITS;
        if (acc > ACC_W'(SAT_MAX))
        begin
            clip = 1'b1;
            return SAT_MAX;
        end
        if (acc < ACC_W'(SAT_MIN))
        begin
            clip = 1'b1;
            return SAT_MIN;
        end
        return acc[DATA_W-1:0];
    endfunction

    task automatic load_identity();
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            cur_mat[i] = (i % 4 == 0) ? FIX_ONE : '0;
        end
        compose_clip = 1'b0;
    endtask

    // Advance the predictor by one accepted request; queue a point for a transform.
    task automatic apply_command(input logic [1:0] command, input mat_t m);
        logic signed [DATA_W-1:0] next_mat [NUM_ELEM];
        logic                     clip;
        point_t                   pt;
        clip = 1'b0;
        case (command)
            CMD_IDENTITY:
            begin
                load_identity();
            end
            CMD_COMPOSE:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        next_mat[r*3+c] = q16_dot3(cur_mat[r*3],   m[c],
                                                   cur_mat[r*3+1], m[3+c],
                                                   cur_mat[r*3+2], m[6+c], clip);
                    end
                end
                cur_mat      = next_mat;
                compose_clip = clip;
            end
            CMD_TRANSFORM:
            begin
                // elem_00 and elem_01 carry the point; the rest is ignored.
                pt.x   = q16_dot3(cur_mat[0], m[0], cur_mat[1], m[1],
                                  cur_mat[2], FIX_ONE, clip);
                pt.y   = q16_dot3(cur_mat[3], m[0], cur_mat[4], m[1],
                                  cur_mat[5], FIX_ONE, clip);
                pt.sat = clip | compose_clip;
                expected_points.push_back(pt);
                n_issued <= n_issued + 1;
            end
            default:
            begin
            end
        endcase
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic mat_t mat(input int e00, e01, e02, e10, e11, e12, e20, e21, e22);
        mat_t m;
        m[0] = e00; m[1] = e01; m[2] = e02;
        m[3] = e10; m[4] = e11; m[5] = e12;
        m[6] = e20; m[7] = e21; m[8] = e22;
        return m;
    endfunction

    // Uniform value in [-lim, lim].
    function automatic logic [DATA_W-1:0] rand_span(input int lim);
        return DATA_W'(int'($urandom_range(2 * lim)) - lim);
    endfunction

    function automatic mat_t rand_words();
        mat_t m;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            m[i] = $urandom;
        end
        return m;
    endfunction

    // A point in elem_00/elem_01 with noise in the ignored elements.
    function automatic mat_t point(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
        mat_t m;
        m    = rand_words();
        m[0] = x;
        m[1] = y;
        return m;
    endfunction

    // A plausible affine matrix: linear part within +-1.25, modest translation,
    // bottom row mostly (0, 0, 1) so that repeated composes grow slowly.
    function automatic mat_t tame_matrix();
        mat_t m;
        m[0] = rand_span(81920);
        m[1] = rand_span(81920);
        m[2] = rand_span(1 << 22);
        m[3] = rand_span(81920);
        m[4] = rand_span(81920);
        m[5] = rand_span(1 << 22);
        if ($urandom_range(3) == 0)
        begin
            m[6] = rand_span(1 << 16);
            m[7] = rand_span(1 << 16);
            m[8] = rand_span(1 << 17);
        end
        else
        begin
            m[6] = '0;
            m[7] = '0;
            m[8] = FIX_ONE;
        end
        return m;
    endfunction

    task automatic add_request(input logic [1:0] command, input mat_t m, input logic drain);
        request_t r;
        r.command    = command;
        r.elem       = m;
        r.wait_drain = drain;
        pending_requests.push_back(r);
        n_total++;
    endtask

    //------------------------------------------------------------------
    // Request driver
    //------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : req_driver
        int       owed;
        request_t nxt;
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.command <= CMD_UNUSED;
            req.elem_00 <= '0;
            req.elem_01 <= '0;
            req.elem_02 <= '0;
            req.elem_10 <= '0;
            req.elem_11 <= '0;
            req.elem_12 <= '0;
            req.elem_20 <= '0;
            req.elem_21 <= '0;
            req.elem_22 <= '0;
        end
        else
        begin
            owed = n_issued - n_returned;
            if (req.valid && req.ready)
            begin
                apply_command(req.command,
                              mat(req.elem_00, req.elem_01, req.elem_02,
                                  req.elem_10, req.elem_11, req.elem_12,
                                  req.elem_20, req.elem_21, req.elem_22));
                n_accepted <= n_accepted + 1;
                if (req.command == CMD_TRANSFORM)
                begin
                    owed++;
                end
            end
            // Hold the current request until it is taken; then offer the next one,
            // or idle at random, or wait for the engine to drain when asked.
            if (!req.valid || req.ready)
            begin
                if (pending_requests.size() != 0
                    && (quiet || $urandom_range(99) >= IDLE_PCT)
                    && (!pending_requests[0].wait_drain || owed == 0))
                begin
                    nxt = pending_requests.pop_front();
                    req.valid   <= 1'b1;
                    req.command <= nxt.command;
                    req.elem_00 <= nxt.elem[0];
                    req.elem_01 <= nxt.elem[1];
                    req.elem_02 <= nxt.elem[2];
                    req.elem_10 <= nxt.elem[3];
                    req.elem_11 <= nxt.elem[4];
                    req.elem_12 <= nxt.elem[5];
                    req.elem_20 <= nxt.elem[6];
                    req.elem_21 <= nxt.elem[7];
                    req.elem_22 <= nxt.elem[8];
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Response side: ready pattern and checker
    //------------------------------------------------------------------

    // Random back-pressure, plus one long hold-off that backs the engine up
    // into its request port.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (!hold_used && cyc >= HOLD_AT)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic flag_mismatch(input string what, input logic signed [DATA_W-1:0] want,
                                 input logic signed [DATA_W-1:0] got);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
        begin
            $display("[%0t] %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, what, want, want, got, got);
        end
    endtask

    always @(posedge clk)
    begin : point_monitor
        point_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            n_returned <= n_returned + 1;
            if (expected_points.size() == 0)
            begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                begin
                    $display("[%0t] unexpected point: x %0d y %0d sat %0b",
                             $time, rsp.out_x, rsp.out_y, rsp.saturated);
                end
            end
            else
            begin
                want = expected_points.pop_front();
                if (rsp.out_x !== want.x)
                begin
                    flag_mismatch("out_x", want.x, rsp.out_x);
                end
                if (rsp.out_y !== want.y)
                begin
                    flag_mismatch("out_y", want.y, rsp.out_y);
                end
                if (rsp.saturated !== want.sat)
                begin
                    flag_mismatch("saturated", DATA_W'(want.sat), DATA_W'(rsp.saturated));
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Cycle count and hang watchdog
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // Count cycles with no handshake on either channel; a long run of them means
    // the engine is stuck.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("affine_2d_transform_engine verification failed");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------

    initial
    begin
        int n_items;
        int n_groups;
        int n_comp;
        int n_pts;

        // Known levels on every engine input from time zero.
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.command = CMD_UNUSED;
        req.elem_00 = '0;
        req.elem_01 = '0;
        req.elem_02 = '0;
        req.elem_10 = '0;
        req.elem_11 = '0;
        req.elem_12 = '0;
        req.elem_20 = '0;
        req.elem_21 = '0;
        req.elem_22 = '0;
        rsp.ready   = 1'b0;

        load_identity();

        // Directed part. Start from the reset matrix: identity must pass points
        // through exactly, extremes and odd values included.
        add_request(CMD_TRANSFORM, point(FIX_ONE, 2 * FIX_ONE), 1'b0);
        add_request(CMD_TRANSFORM, point(SAT_MAX, SAT_MIN), 1'b0);
        add_request(CMD_TRANSFORM, point(-1, 1), 1'b0);
        // Unused code with every bit set: must be dropped with no effect.
        add_request(CMD_UNUSED, mat(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
        // Scale and extreme translation; the compose itself stays in range.
        add_request(CMD_COMPOSE, mat(2 * FIX_ONE, 0, SAT_MAX,
                                     0, -32768, SAT_MIN,
                                     0, 0, FIX_ONE), 1'b0);
        // x clips on this point alone, y does not.
        add_request(CMD_TRANSFORM, point(SAT_MAX, SAT_MIN), 1'b0);
        add_request(CMD_TRANSFORM, point(0, 0), 1'b0);
        // Doubling the extreme translation clips inside the compose: the flag
        // must then stick to every point until the next identity load or compose.
        add_request(CMD_COMPOSE, mat(2 * FIX_ONE, 0, 0,
                                     0, 2 * FIX_ONE, 0,
                                     0, 0, 2 * FIX_ONE), 1'b0);
        add_request(CMD_TRANSFORM, point(0, 0), 1'b0);
        add_request(CMD_IDENTITY, rand_words(), 1'b0);
        add_request(CMD_TRANSFORM, point(0, 0), 1'b0);
        // Most negative everywhere: exact once, clipping positive the second time.
        add_request(CMD_COMPOSE, mat(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                                     SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0);
        add_request(CMD_TRANSFORM, point(SAT_MAX, SAT_MAX), 1'b0);
        add_request(CMD_COMPOSE, mat(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                                     SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0);
        add_request(CMD_TRANSFORM, point(1, -1), 1'b0);
        add_request(CMD_IDENTITY, mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        // Smallest negative fraction everywhere: floor rounding of negative sums.
        add_request(CMD_COMPOSE, mat(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
        add_request(CMD_TRANSFORM, point(SAT_MAX, SAT_MAX), 1'b0);
        add_request(CMD_IDENTITY, rand_words(), 1'b0);
        add_request(CMD_COMPOSE, mat(21845, -21846, -1, 3, -5, 7, 0, 0, FIX_ONE), 1'b0);
        add_request(CMD_TRANSFORM, point(-3, 5), 1'b0);
        add_request(CMD_TRANSFORM, point(32'h5555_5555, 32'hAAAA_AAAA), 1'b0);
        add_request(CMD_IDENTITY, rand_words(), 1'b0);
        add_request(CMD_UNUSED, mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);

        // Random part: groups of an optional identity load, a few composes and a
        // run of points, with dropped codes and full-range matrices as noise.
        n_items  = 0;
        n_groups = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            n_groups++;
            // Now and then make the sender wait for all points to come back.
            if (n_groups % 40 == 20)
            begin
                add_request(CMD_TRANSFORM, point($urandom, $urandom), 1'b1);
                n_items++;
            end
            if ($urandom_range(3) == 0)
            begin
                add_request(CMD_IDENTITY, rand_words(), 1'b0);
                n_items++;
            end
            n_comp = $urandom_range(2);
            for (int i = 0; i < n_comp; i++)
            begin
                add_request(CMD_COMPOSE,
                            ($urandom_range(7) == 0) ? rand_words() : tame_matrix(), 1'b0);
                n_items++;
            end
            n_pts = $urandom_range(8, 2);
            for (int i = 0; i < n_pts; i++)
            begin
                if ($urandom_range(5) == 0)
                begin
                    add_request(CMD_TRANSFORM, point($urandom, $urandom), 1'b0);
                end
                else
                begin
                    add_request(CMD_TRANSFORM,
                                point(rand_span(1 << 24), rand_span(1 << 24)), 1'b0);
                end
                n_items++;
            end
            if ($urandom_range(29) == 0)
            begin
                add_request(CMD_UNUSED, rand_words(), 1'b0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every point to come back.
        while (!(n_accepted == n_total && n_issued == n_returned))
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_points.size() != 0)
        begin
            n_fail++;
            $display("%0d expected points never arrived", expected_points.size());
        end
        if (n_fail == 0)
        begin
            $display("affine_2d_transform_engine verification clean");
        end
        else
        begin
            $display("affine_2d_transform_engine verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/aff2d_pkg.sv
rtl/core/aff2d_if.sv
rtl/core/aff2d_mac.sv
rtl/core/affine_2d_transform_engine.sv
dv/tb_affine_2d_transform_engine.sv
